// ===== rtl/core/mfda_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Max-flow package
// Shared constants, the command enum and the status struct that join the controller
// and the datapath of the max-flow core.
// ----------------------------------------------------------------------------
package mfda_pkg;

    localparam int MAX_NODES_DEF = 16;
    localparam int CAP_BITS_DEF  = 16;
    localparam int FLOW_BITS     = 20;
    localparam int CFG_BITS      = 5;
    localparam int IDX_BITS      = 2;

    // Configuration register indexes.
    localparam logic [IDX_BITS-1:0] REG_SOURCE = 2'd0;
    localparam logic [IDX_BITS-1:0] REG_SINK   = 2'd1;
    localparam logic [IDX_BITS-1:0] REG_COUNT  = 2'd2;

    // Datapath operations, one per controller step.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,       // write the requested entry
        OP_SEARCH_INIT,// clear marks, push source
        OP_SCAN_RD,    // read residual (top, scan) for the scan column
        OP_SCAN_EVAL,  // evaluate that column
        OP_BN_RD,      // read residual (parent, node) during bottleneck walk
        OP_BN_EVAL,
        OP_UPD_RD,     // read forward edge
        OP_UPD_FWD,    // write forward edge, read reverse edge
        OP_UPD_REV,    // write reverse edge, step to parent
        OP_ACCUM,      // add bottleneck to total
        OP_CLEAR,      // clear one residual row entry
        OP_ZERO        // answer is zero
    } t_op;

    typedef struct packed {
        logic found;     // scan hit an unvisited neighbour with capacity
        logic at_sink;   // scan column is the sink
        logic scan_end;  // scan column is the last one below the node count
        logic stack_empty;
        logic walk_done; // parent walk reached the source
        logic clear_done;
        logic trivial;   // endpoints invalid or equal
    } t_status;

endpackage

// ===== rtl/core/mfda_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Max-flow datapath
// Residual matrix memory, marks, parent table, stack, bottleneck and total.
// ----------------------------------------------------------------------------
module mfda_datapath
    import mfda_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int CAP_BITS  = CAP_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_op                  i_op,
    input  logic [3:0]           i_from_node,
    input  logic [3:0]           i_to_node,
    input  logic [15:0]          i_capacity,
    input  logic [3:0]           i_source,
    input  logic [3:0]           i_sink,
    input  logic [4:0]           i_count,
    output t_status              o_status,
    output logic [FLOW_BITS-1:0] o_total
);

    localparam int NB    = $clog2(MAX_NODES);
    localparam int AB    = 2 * NB;
    localparam int RB    = CAP_BITS + 1;
    // The memory spans the full row/column address space.
    localparam int DEPTH = 1 << AB;
    localparam int CB    = NB + 1;

    logic [RB-1:0]        r_mem [DEPTH];
    logic [RB-1:0]        r_rd;
    logic [MAX_NODES-1:0] r_mark;
    logic [NB-1:0]        r_parent [MAX_NODES];
    logic [NB-1:0]        r_stack [MAX_NODES];
    logic [CB-1:0]        r_sp;
    logic [CB-1:0]        r_scan;
    logic [NB-1:0]        r_walk;
    logic [RB-1:0]        r_bn;
    logic [AB:0]          r_clr;
    logic [FLOW_BITS-1:0] r_total;

    logic [CB-1:0]   w_n;
    logic [NB-1:0]   w_src;
    logic [NB-1:0]   w_snk;
    logic [NB-1:0]   w_top;
    logic [NB-1:0]   w_scan;
    logic [NB-1:0]   w_par;
    logic [CB+3:0]   w_cnt_ext;
    logic            w_ld_ok;
    logic [RB-1:0]   w_ld_cap;
    logic [AB-1:0]   w_raddr;
    logic            w_we;
    logic [AB-1:0]   w_waddr;
    logic [RB-1:0]   w_wdata;
    logic [FLOW_BITS:0] w_sum;

    // Effective node count, endpoints and stack top.
    always_comb begin
        w_cnt_ext = (CB + 4)'(i_count);
        if (i_count == 5'd0)
            w_n = CB'(1);
        else if (w_cnt_ext > (CB + 4)'(MAX_NODES))
            w_n = CB'(MAX_NODES);
        else
            w_n = CB'(i_count);
        w_src  = NB'(i_source);
        w_snk  = NB'(i_sink);
        w_top  = r_stack[NB'(r_sp - CB'(1))];
        w_scan = r_scan[NB-1:0];
        w_par  = r_parent[r_walk];
    end

    // Load entry: ignore out-of-matrix indexes, saturate wide capacities.
    always_comb begin
        w_ld_ok = ((CB + 4)'(i_from_node) < (CB + 4)'(MAX_NODES)) &&
                  ((CB + 4)'(i_to_node) < (CB + 4)'(MAX_NODES));
        if (CAP_BITS < 16 && (32'(i_capacity) > ((32'd1 << CAP_BITS) - 32'd1)))
            w_ld_cap = RB'((32'd1 << CAP_BITS) - 32'd1);
        else
            w_ld_cap = RB'(i_capacity);
    end

    // Memory address and write selection.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = '0;
        w_wdata = '0;
        w_raddr = '0;
        case (i_op)
            OP_LOAD: begin
                w_we    = w_ld_ok;
                w_waddr = {NB'(i_from_node), NB'(i_to_node)};
                w_wdata = w_ld_cap;
            end
            OP_SCAN_RD: w_raddr = {w_top, w_scan};
            OP_BN_RD:   w_raddr = {w_par, r_walk};
            OP_UPD_RD:  w_raddr = {w_par, r_walk};
            OP_UPD_FWD: begin
                w_we    = 1'b1;
                w_waddr = {w_par, r_walk};
                w_wdata = r_rd - r_bn;
                w_raddr = {r_walk, w_par};
            end
            OP_UPD_REV: begin
                w_we    = 1'b1;
                w_waddr = {r_walk, w_par};
                w_wdata = r_rd + r_bn;
            end
            OP_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr[AB-1:0];
            end
            default: ;
        endcase
    end

    // Residual memory with registered read.
    always_ff @(posedge i_clk) begin
        if (w_we)
            r_mem[w_waddr] <= w_wdata;
        r_rd <= r_mem[w_raddr];
    end

    assign w_sum = (FLOW_BITS + 1)'(r_total) + (FLOW_BITS + 1)'(r_bn);

    // Search, walk and total registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark  <= '0;
            r_sp    <= '0;
            r_scan  <= '0;
            r_clr   <= '0;
            r_total <= '0;
        end else begin
            case (i_op)
                OP_SEARCH_INIT: begin
                    r_mark     <= {{(MAX_NODES-1){1'b0}}, 1'b1} << w_src;
                    r_stack[0] <= w_src;
                    r_sp       <= CB'(1);
                    r_scan     <= '0;
                end
                OP_SCAN_EVAL: begin
                    if (!r_mark[w_scan] && r_rd != '0) begin
                        r_parent[w_scan] <= w_top;
                        r_mark[w_scan]   <= 1'b1;
                        r_scan           <= '0;
                        if (w_scan == w_snk) begin
                            r_walk <= w_snk;
                            r_bn   <= '1;
                        end else if (r_sp < CB'(MAX_NODES)) begin
                            r_stack[r_sp[NB-1:0]] <= w_scan;
                            r_sp                  <= r_sp + CB'(1);
                        end
                    end else if (r_scan + CB'(1) >= w_n) begin
                        r_sp   <= r_sp - CB'(1);
                        r_scan <= '0;
                    end else begin
                        r_scan <= r_scan + CB'(1);
                    end
                end
                OP_BN_EVAL: begin
                    if (r_rd < r_bn)
                        r_bn <= r_rd;
                    if (w_par == w_src)
                        r_walk <= w_snk;
                    else
                        r_walk <= w_par;
                end
                OP_UPD_REV: r_walk <= w_par;
                OP_ACCUM: begin
                    if (w_sum > (FLOW_BITS + 1)'({FLOW_BITS{1'b1}}))
                        r_total <= '1;
                    else
                        r_total <= w_sum[FLOW_BITS-1:0];
                end
                OP_CLEAR: begin
                    if (r_clr == (AB + 1)'(DEPTH - 1)) begin
                        r_clr   <= '0;
                        r_total <= '0;
                    end else begin
                        r_clr <= r_clr + (AB + 1)'(1);
                    end
                end
                OP_ZERO: r_total <= '0;
                default: ;
            endcase
        end
    end

    // Status toward the controller. The stack reads empty while one node remains on it.
    always_comb begin
        o_status.found       = !r_mark[w_scan] && (r_rd != '0);
        o_status.at_sink     = (w_scan == w_snk);
        o_status.scan_end    = (r_scan + CB'(1) >= w_n);
        o_status.stack_empty = (r_sp == CB'(1));
        o_status.walk_done   = (w_par == w_src);
        o_status.clear_done  = (r_clr == (AB + 1)'(DEPTH - 1));
        o_status.trivial     = ((CB + 4)'(i_source) >= (CB + 4)'(w_n)) ||
                               ((CB + 4)'(i_sink) >= (CB + 4)'(w_n)) ||
                               (i_source == i_sink);
    end

    assign o_total = r_total;

endmodule

// ===== rtl/core/mfda_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Max-flow controller
// Sequences loading, depth-first search, augmentation, answer and clearing.
// ----------------------------------------------------------------------------
module mfda_ctrl
    import mfda_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_accept,
    input  logic    i_last,
    input  t_status i_status,
    output t_op     o_op,
    output logic    o_busy,
    output logic    o_done
);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_INIT, S_SRD, S_SEV, S_BRD, S_BEV,
        S_URD, S_UFWD, S_UREV, S_ACC, S_OUT, S_CLR
    } t_state;

    t_state r_state;
    logic   r_done;

    // Operation issued in each state.
    always_comb begin
        unique case (r_state)
            S_IDLE:  o_op = i_accept ? OP_LOAD : OP_NONE;
            S_CHECK: o_op = i_status.trivial ? OP_ZERO : OP_NONE;
            S_INIT:  o_op = OP_SEARCH_INIT;
            S_SRD:   o_op = OP_SCAN_RD;
            S_SEV:   o_op = OP_SCAN_EVAL;
            S_BRD:   o_op = OP_BN_RD;
            S_BEV:   o_op = OP_BN_EVAL;
            S_URD:   o_op = OP_UPD_RD;
            S_UFWD:  o_op = OP_UPD_FWD;
            S_UREV:  o_op = OP_UPD_REV;
            S_ACC:   o_op = OP_ACCUM;
            S_OUT:   o_op = OP_NONE;
            S_CLR:   o_op = OP_CLEAR;
            default: o_op = OP_NONE;
        endcase
    end

    // State and result strobe. Reset starts with a clearing pass of the memory.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE:  if (i_accept && i_last) r_state <= S_CHECK;
                S_CHECK: r_state <= i_status.trivial ? S_OUT : S_INIT;
                S_INIT:  r_state <= S_SRD;
                S_SRD:   r_state <= S_SEV;
                S_SEV: begin
                    if (i_status.found && i_status.at_sink)
                        r_state <= S_BRD;
                    else if (!i_status.found && i_status.scan_end && i_status.stack_empty)
                        r_state <= S_OUT;
                    else
                        r_state <= S_SRD;
                end
                S_BRD:   r_state <= S_BEV;
                S_BEV:   r_state <= i_status.walk_done ? S_URD : S_BRD;
                S_URD:   r_state <= S_UFWD;
                S_UFWD:  r_state <= S_UREV;
                S_UREV:  r_state <= i_status.walk_done ? S_ACC : S_URD;
                S_ACC:   r_state <= S_INIT;
                S_OUT: begin
                    r_done  <= 1'b1;
                    r_state <= S_CLR;
                end
                S_CLR:   if (i_status.clear_done) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

// ===== rtl/core/max_flow_dfs_augment_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Max-flow core
// Loads a capacity matrix and computes the source-to-sink maximum flow with
// depth-first augmenting paths.
// ----------------------------------------------------------------------------
// Channel   Handshake            Payload
// request   i_start / busy       i_from_node, i_to_node, i_capacity, i_last_entry
// result    o_valid              o_max_flow
// config    i_cfg_we             i_cfg_index, i_cfg_data
//
// An entry that is not last is written and the core stays idle, ready for another.
// The last entry starts the solve: each search step is a memory read, then an
// evaluate; each path edge is a bottleneck read and evaluate, then an update
// (read, forward write, reverse write); time grows with path count.
// After reset and after each answer a clearing pass over the whole residual
// memory runs while busy stays high. Reset is synchronous, active low.
// The result strobe lasts one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module max_flow_dfs_augment_core
    import mfda_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int CAP_BITS  = CAP_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 busy,
    input  logic [3:0]           i_from_node,
    input  logic [3:0]           i_to_node,
    input  logic [15:0]          i_capacity,
    input  logic                 i_last_entry,
    output logic                 o_valid,
    output logic [FLOW_BITS-1:0] o_max_flow,
    input  logic                 i_cfg_we,
    input  logic [IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_BITS-1:0]  i_cfg_data
);

    logic [3:0] r_source;
    logic [3:0] r_sink;
    logic [4:0] r_count;
    logic       w_accept;
    t_op        w_op;
    t_status    w_status;

    assign w_accept = i_start && !busy;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source <= 4'd0;
            r_sink   <= 4'd15;
            r_count  <= 5'd16;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SOURCE: r_source <= i_cfg_data[3:0];
                REG_SINK:   r_sink   <= i_cfg_data[3:0];
                REG_COUNT:  r_count  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mfda_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_last   (i_last_entry),
        .i_status (w_status),
        .o_op     (w_op),
        .o_busy   (busy),
        .o_done   (o_valid)
    );

    mfda_datapath #(
        .MAX_NODES (MAX_NODES),
        .CAP_BITS  (CAP_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (w_op),
        .i_from_node (i_from_node),
        .i_to_node   (i_to_node),
        .i_capacity  (i_capacity),
        .i_source    (r_source),
        .i_sink      (r_sink),
        .i_count     (r_count),
        .o_status    (w_status),
        .o_total     (o_max_flow)
    );

endmodule
